// ===== hdl/llrlc_pkg.sv =====
// Shared types and constants for the levelled trace ring.
`timescale 1ns / 1ps

package llrlc_pkg;

    // Ring depth must be a power of two; slot indexes are low cursor bits.
    localparam int RING_DEPTH = 64;
    localparam int RING_AW    = $clog2(RING_DEPTH);

    localparam logic [31:0] SAT_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_DROP  = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    typedef struct packed {
        logic        line;        // a line is returned
        logic [31:0] cursor;      // cursor after skip and advance
        logic [31:0] lost;        // lost count for this request
    } t_read_res;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? SAT_MAX : s[31:0];
    endfunction

endpackage

// ===== hdl/leveled_log_ring_with_loss_count_unit.sv =====
// Top level of the levelled trace ring with loss counting.
`timescale 1ns / 1ps

// One request per cycle, sustained while the result side does not stall. A
// request is held in an input register while its ring slot and counters are
// worked out, then moves to the result register together with the ring read
// data; while the result side stalls, the result register holds. The ring is
// a single-port-write, single-read memory of RING_DEPTH entries; a write
// request stores its line as it leaves the input register, so a read in the
// next cycle already sees it.
module leveled_log_ring_with_loss_count_unit import llrlc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [2:0]  i_entry_level,
    input  logic [31:0] i_entry_time_ms,
    input  logic [63:0] i_entry_payload,
    input  logic [31:0] i_read_cursor,
    input  logic [31:0] i_drop_count,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_line_valid,
    output logic [2:0]  o_line_level,
    output logic [31:0] o_line_time_ms,
    output logic [63:0] o_line_payload,
    output logic [31:0] o_next_cursor,
    output logic [31:0] o_lost_count,
    output logic [31:0] o_total_written
);

    // ring storage
    logic [2:0]  r_mem_level   [RING_DEPTH];
    logic [31:0] r_mem_time    [RING_DEPTH];
    logic [63:0] r_mem_payload [RING_DEPTH];

    logic [2:0]  r_threshold;
    logic [31:0] r_lines_written;
    logic [31:0] r_drops;

    // input stage
    logic        r_a_vld;
    t_opcode     r_a_op;
    logic [2:0]  r_a_level;
    logic [31:0] r_a_time;
    logic [63:0] r_a_payload;
    logic [31:0] r_a_cursor;
    logic [31:0] r_a_dcount;

    // result stage
    logic        r_o_vld;
    logic        r_o_line;
    logic [31:0] r_o_cursor;
    logic [31:0] r_o_lost;
    logic [31:0] r_o_total;
    logic [2:0]  r_rd_level;
    logic [31:0] r_rd_time;
    logic [63:0] r_rd_payload;

    logic        out_free;
    logic        a_adv;
    logic        in_acc;
    logic        wr_store;
    logic        is_read;
    t_read_res   rd_res;
    logic [31:0] rd_pos;
    logic [RING_AW-1:0] rd_slot;
    logic [RING_AW-1:0] wr_slot;
    logic [31:0] n_lines_written;
    logic [31:0] n_drops;

    llrlc_read_calc u_read_calc (
        .i_cursor        (r_a_cursor),
        .i_lines_written (r_lines_written),
        .i_drops         (r_drops),
        .o_res           (rd_res)
    );

    always_comb begin
        out_free   = !r_o_vld || !i_out_stall;
        a_adv      = r_a_vld && out_free;
        o_in_stall = r_a_vld && !out_free;
        in_acc     = i_in_valid && !o_in_stall;

        is_read  = (r_a_op == OP_READ);
        wr_store = (r_a_op == OP_WRITE) && (r_a_level != 3'd0) && (r_a_level <= r_threshold);
        wr_slot  = r_lines_written[RING_AW-1:0];
        rd_pos   = rd_res.cursor - 32'd1;
        rd_slot  = rd_pos[RING_AW-1:0];

        n_lines_written = r_lines_written;
        n_drops         = r_drops;
        case (r_a_op)
            OP_WRITE: begin
                if (wr_store) begin
                    n_lines_written = r_lines_written + 32'd1;
                end
            end
            OP_READ: begin
                if (rd_res.line) begin
                    n_drops = '0;
                end
            end
            OP_DROP: begin
                n_drops = sat_add32(r_drops, r_a_dcount);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold     <= 3'd2;
            r_lines_written <= '0;
            r_drops         <= '0;
            r_a_vld         <= 1'b0;
            r_o_vld         <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_threshold <= i_cfg_wr_data;
            end
            if (in_acc) begin
                r_a_vld <= 1'b1;
            end else if (a_adv) begin
                r_a_vld <= 1'b0;
            end
            if (a_adv) begin
                r_o_vld         <= 1'b1;
                r_lines_written <= n_lines_written;
                r_drops         <= n_drops;
            end else if (!i_out_stall) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_op      <= t_opcode'(i_opcode);
            r_a_level   <= i_entry_level;
            r_a_time    <= i_entry_time_ms;
            r_a_payload <= i_entry_payload;
            r_a_cursor  <= i_read_cursor;
            r_a_dcount  <= i_drop_count;
        end
        if (a_adv) begin
            r_o_line   <= is_read && rd_res.line;
            r_o_cursor <= is_read ? rd_res.cursor : '0;
            r_o_lost   <= is_read ? rd_res.lost : '0;
            r_o_total  <= n_lines_written;
        end
    end

    // ring memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (a_adv && wr_store) begin
            r_mem_level[wr_slot]   <= r_a_level;
            r_mem_time[wr_slot]    <= r_a_time;
            r_mem_payload[wr_slot] <= r_a_payload;
        end
        if (a_adv) begin
            r_rd_level   <= r_mem_level[rd_slot];
            r_rd_time    <= r_mem_time[rd_slot];
            r_rd_payload <= r_mem_payload[rd_slot];
        end
    end

    always_comb begin
        o_out_valid     = r_o_vld;
        o_line_valid    = r_o_line;
        o_line_level    = r_o_line ? r_rd_level : '0;
        o_line_time_ms  = r_o_line ? r_rd_time : '0;
        o_line_payload  = r_o_line ? r_rd_payload : '0;
        o_next_cursor   = r_o_cursor;
        o_lost_count    = r_o_lost;
        o_total_written = r_o_total;
    end

endmodule

// ===== hdl/llrlc_read_calc.sv =====
// Cursor skip, loss count and line check for a read request.
`timescale 1ns / 1ps

module llrlc_read_calc import llrlc_pkg::*; (
    input  logic [31:0] i_cursor,
    input  logic [31:0] i_lines_written,
    input  logic [31:0] i_drops,
    output t_read_res   o_res
);

    localparam logic [31:0] DEPTH_W = 32'(RING_DEPTH);

    logic [31:0] oldest;
    logic        has_line;
    logic        skip;
    logic [31:0] cur_skip;
    logic [31:0] lost_base;

    always_comb begin
        oldest    = (i_lines_written > DEPTH_W) ? (i_lines_written - DEPTH_W) : '0;
        has_line  = (i_cursor < i_lines_written);
        skip      = (i_cursor < oldest);
        cur_skip  = skip ? oldest : i_cursor;
        lost_base = has_line ? i_drops : '0;

        o_res.line   = has_line;
        o_res.cursor = has_line ? (cur_skip + 32'd1) : i_cursor;
        o_res.lost   = skip ? sat_add32(lost_base, oldest - i_cursor) : lost_base;
    end

endmodule

// ===== hdl/llrlc_checker.sv =====
// Port-level checks for the levelled trace ring, bound to the top level.
`timescale 1ns / 1ps

module llrlc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_line_valid,
    input logic [2:0]  o_line_level,
    input logic [31:0] o_line_time_ms,
    input logic [63:0] o_line_payload,
    input logic [31:0] o_next_cursor,
    input logic [31:0] o_lost_count,
    input logic [31:0] o_total_written
);

    // reset empties the result stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_next_cursor)
            && $stable(o_lost_count) && $stable(o_total_written)
            && $stable(o_line_valid))
        else $error("stalled result changed");

    // no line means zeroed line fields
    a_no_line_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_line_valid |-> o_line_level == 3'd0
            && o_line_time_ms == 32'd0 && o_line_payload == 64'd0)
        else $error("line fields set without a line");

    // a returned line was stored, so its level is nonzero and something was written
    a_line_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_line_valid |-> o_line_level != 3'd0 && o_total_written != 32'd0)
        else $error("returned line never stored");

endmodule

bind leveled_log_ring_with_loss_count_unit llrlc_checker u_llrlc_checker (.*);

// ===== bench/tb_leveled_log_ring_with_loss_count_unit.sv =====
// Self-checking bench for the levelled trace ring: directed cases, then randomised phases.
`timescale 1ns / 1ps

module tb_leveled_log_ring_with_loss_count_unit;
    import llrlc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_LEN   = 155;

    typedef struct packed {
        t_opcode     op;
        logic [2:0]  level;
        logic [31:0] time_ms;
        logic [63:0] payload;
        logic [31:0] cursor;
        logic [31:0] drops;
    } t_log_request;

    typedef struct packed {
        logic        line_valid;
        logic [2:0]  level;
        logic [31:0] time_ms;
        logic [63:0] payload;
        logic [31:0] next_cursor;
        logic [31:0] lost;
        logic [31:0] total;
    } t_ring_reply;

    typedef enum {CUR_GIVEN, CUR_FOLLOW, CUR_BEHIND, CUR_AHEAD} t_cursor_pick;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_opcode     req_op = OP_NONE;
    logic [2:0]  req_level = '0;
    logic [31:0] req_time_ms = '0;
    logic [63:0] req_payload = '0;
    logic [31:0] req_cursor = '0;
    logic [31:0] req_drops = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        line_valid;
    logic [2:0]  line_level;
    logic [31:0] line_time_ms;
    logic [63:0] line_payload;
    logic [31:0] next_cursor;
    logic [31:0] lost_count;
    logic [31:0] total_written;

    // shadow of the ring and its counters
    logic [2:0]  ring_level   [RING_DEPTH];
    logic [31:0] ring_time    [RING_DEPTH];
    logic [63:0] ring_payload [RING_DEPTH];
    logic [31:0] written_total = '0;
    logic [31:0] drops_pending = '0;
    logic [31:0] reader_cursor = '0;
    logic [2:0]  threshold_q = 3'd2;

    t_ring_reply expected_replies[$];

    int errors = 0;
    int requests_taken = 0;
    int lines_returned = 0;
    int overrun_skips = 0;
    int writes_rejected = 0;
    int drop_saturations = 0;
    int cycle_count = 0;
    int out_hold = 0;
    bit in_calm = 1'b0;
    bit out_calm = 1'b0;

    leveled_log_ring_with_loss_count_unit uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_opcode        (req_op),
        .i_entry_level   (req_level),
        .i_entry_time_ms (req_time_ms),
        .i_entry_payload (req_payload),
        .i_read_cursor   (req_cursor),
        .i_drop_count    (req_drops),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_line_valid    (line_valid),
        .o_line_level    (line_level),
        .o_line_time_ms  (line_time_ms),
        .o_line_payload  (line_payload),
        .o_next_cursor   (next_cursor),
        .o_lost_count    (lost_count),
        .o_total_written (total_written)
    );

    always #6 clk = ~clk;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d replies outstanding", $time,
                     expected_replies.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [31:0] add_clamped(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic t_ring_reply predict_reply(input t_log_request r);
        t_ring_reply y;
        logic [31:0] oldest;
        logic [31:0] cur;
        y = '0;
        case (r.op)
            OP_WRITE: begin
                if (r.level != 3'd0 && r.level <= threshold_q) begin
                    ring_level[written_total[RING_AW-1:0]]   = r.level;
                    ring_time[written_total[RING_AW-1:0]]    = r.time_ms;
                    ring_payload[written_total[RING_AW-1:0]] = r.payload;
                    written_total = written_total + 32'd1;
                end else begin
                    writes_rejected++;
                end
            end
            OP_READ: begin
                oldest = (written_total > RING_DEPTH) ? written_total - RING_DEPTH : '0;
                cur = r.cursor;
                if (cur < written_total) begin
                    y.lost = drops_pending;
                    drops_pending = '0;
                end
                if (cur < oldest) begin
                    y.lost = add_clamped(y.lost, oldest - cur);
                    cur = oldest;
                    overrun_skips++;
                end
                if (cur < written_total) begin
                    y.line_valid = 1'b1;
                    y.level   = ring_level[cur[RING_AW-1:0]];
                    y.time_ms = ring_time[cur[RING_AW-1:0]];
                    y.payload = ring_payload[cur[RING_AW-1:0]];
                    cur = cur + 32'd1;
                    lines_returned++;
                end
                y.next_cursor = cur;
                reader_cursor = cur;
            end
            OP_DROP: begin
                drops_pending = add_clamped(drops_pending, r.drops);
                if (drops_pending == 32'hFFFF_FFFF)
                    drop_saturations++;
            end
            default: ;
        endcase
        y.total = written_total;
        return y;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    // accepted requests feed the shadow model; accepted replies are checked in order
    always @(posedge clk) begin
        t_ring_reply want;
        if (rst_n) begin
            if (cfg_wr_en)
                threshold_q = cfg_wr_data;
            if (in_valid && !in_stall) begin
                expected_replies.push_back(predict_reply(t_log_request'{req_op, req_level,
                                                         req_time_ms, req_payload,
                                                         req_cursor, req_drops}));
                requests_taken++;
            end
            if (out_valid && !out_stall) begin
                if (expected_replies.size() == 0) begin
                    errors++;
                    $display("%0t: reply with none expected, expected nothing actual %0h",
                             $time, total_written);
                end else begin
                    want = expected_replies.pop_front();
                    check_field("line_valid", 64'(want.line_valid), 64'(line_valid));
                    check_field("line_level", 64'(want.level), 64'(line_level));
                    check_field("line_time_ms", 64'(want.time_ms), 64'(line_time_ms));
                    check_field("line_payload", want.payload, line_payload);
                    check_field("next_cursor", 64'(want.next_cursor), 64'(next_cursor));
                    check_field("lost_count", 64'(want.lost), 64'(lost_count));
                    check_field("total_written", 64'(want.total), 64'(total_written));
                end
                out_hold = out_calm ? 0 : $urandom_range(0, 19);
            end
        end
    end

    always @(negedge clk) begin
        if (out_hold > 0) begin
            out_stall <= 1'b1;
            out_hold--;
        end else begin
            out_stall <= 1'b0;
        end
    end

    task automatic send_request(input t_log_request r, input t_cursor_pick pick);
        int gap;
        gap = in_calm ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        case (pick)
            CUR_FOLLOW: r.cursor = reader_cursor;
            CUR_BEHIND: r.cursor = written_total - $urandom_range(0, 100);
            CUR_AHEAD:  r.cursor = written_total + $urandom_range(0, 3);
            default: ;
        endcase
        req_op      <= r.op;
        req_level   <= r.level;
        req_time_ms <= r.time_ms;
        req_payload <= r.payload;
        req_cursor  <= r.cursor;
        req_drops   <= r.drops;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_fixed(input t_opcode op, input logic [2:0] lvl,
                              input logic [31:0] tms, input logic [63:0] pay,
                              input logic [31:0] cur, input logic [31:0] drops);
        send_request(t_log_request'{op, lvl, tms, pay, cur, drops}, CUR_GIVEN);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_threshold(input logic [2:0] value);
        drain();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic test_empty_ring();
        send_fixed(OP_READ, 3'($urandom), $urandom, {$urandom, $urandom}, 32'd0, $urandom);
        send_fixed(OP_READ, 3'($urandom), $urandom, {$urandom, $urandom}, 32'hFFFF_FFFF,
                   $urandom);
        send_fixed(OP_NONE, 3'd7, $urandom, {$urandom, $urandom}, $urandom, $urandom);
        send_fixed(OP_DROP, 3'($urandom), $urandom, {$urandom, $urandom}, $urandom, 32'd0);
    endtask

    task automatic test_write_filter();
        send_fixed(OP_WRITE, 3'd0, $urandom, {$urandom, $urandom}, $urandom, $urandom);
        send_fixed(OP_WRITE, 3'd3, $urandom, {$urandom, $urandom}, $urandom, $urandom);
        send_fixed(OP_WRITE, 3'd1, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, $urandom,
                   $urandom);
        send_fixed(OP_WRITE, 3'd2, 32'd0, 64'd0, $urandom, $urandom);
    endtask

    task automatic test_drop_saturation();
        send_fixed(OP_DROP, 3'($urandom), $urandom, {$urandom, $urandom}, $urandom,
                   32'hFFFF_FFF0);
        send_fixed(OP_DROP, 3'($urandom), $urandom, {$urandom, $urandom}, $urandom,
                   32'h20);
        send_fixed(OP_READ, 3'($urandom), $urandom, {$urandom, $urandom}, 32'd0, $urandom);
        send_fixed(OP_READ, 3'($urandom), $urandom, {$urandom, $urandom}, 32'd1, $urandom);
        send_fixed(OP_READ, 3'($urandom), $urandom, {$urandom, $urandom}, 32'd2, $urandom);
    endtask

    task automatic test_threshold_extremes();
        set_threshold(3'd0);
        send_fixed(OP_WRITE, 3'd1, $urandom, {$urandom, $urandom}, $urandom, $urandom);
        send_fixed(OP_WRITE, 3'd0, $urandom, {$urandom, $urandom}, $urandom, $urandom);
        set_threshold(3'd7);
        send_fixed(OP_WRITE, 3'd7, $urandom, {$urandom, $urandom}, $urandom, $urandom);
        send_fixed(OP_WRITE, 3'd4, $urandom, {$urandom, $urandom}, $urandom, $urandom);
        send_fixed(OP_READ, 3'($urandom), $urandom, {$urandom, $urandom}, 32'd2, $urandom);
        send_fixed(OP_READ, 3'($urandom), $urandom, {$urandom, $urandom}, 32'd3, $urandom);
    endtask

    // mostly writes and a reader walking the ring, with stray cursors and drop reports
    task automatic test_random_phase(input logic [2:0] thr, input int count);
        t_log_request r;
        t_cursor_pick pick;
        int roll;
        set_threshold(thr);
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                in_calm  = ($urandom_range(0, 2) == 0);
                out_calm = ($urandom_range(0, 2) == 0);
            end
            r.time_ms = $urandom;
            r.payload = {$urandom, $urandom};
            r.cursor  = $urandom;
            r.level   = 3'($urandom_range(0, 7));
            roll = $urandom_range(0, 99);
            if (roll < 70)
                r.drops = $urandom_range(0, 20);
            else if (roll < 90)
                r.drops = $urandom;
            else
                r.drops = 32'hFFFF_FFFF - $urandom_range(0, 15);
            pick = CUR_GIVEN;
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
                r.op = OP_WRITE;
                if (thr != 3'd0 && $urandom_range(0, 9) < 7)
                    r.level = 3'($urandom_range(1, thr));
            end else if (roll < 80) begin
                r.op = OP_READ;
                roll = $urandom_range(0, 99);
                if (roll < 50)
                    pick = CUR_FOLLOW;
                else if (roll < 75)
                    pick = CUR_BEHIND;
                else if (roll < 90)
                    pick = CUR_AHEAD;
            end else if (roll < 93) begin
                r.op = OP_DROP;
            end else begin
                r.op = OP_NONE;
            end
            send_request(r, pick);
        end
    endtask

    initial begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        test_empty_ring();
        test_write_filter();
        test_drop_saturation();
        test_threshold_extremes();
        test_random_phase(3'd7, PHASE_LEN);
        test_random_phase(3'd3, PHASE_LEN);
        test_random_phase(3'd0, PHASE_LEN);
        test_random_phase(3'd5, PHASE_LEN);
        test_random_phase(3'd1, PHASE_LEN);
        test_random_phase(3'd4, PHASE_LEN);
        test_random_phase(3'd6, PHASE_LEN);
        test_random_phase(3'd2, PHASE_LEN);

        drain();
        repeat (8) @(posedge clk);
        $display("Ran %0d requests across all eight thresholds: %0d lines read back,",
                 requests_taken, lines_returned);
        $display("%0d overrun skips, %0d writes filtered out, %0d saturated drop reports.",
                 overrun_skips, writes_rejected, drop_saturations);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
